// ===== rtl/bstse_pkg.sv =====
// Shared types, constants and the key order function for the BST set engine.
// No dependencies; imported by bstse_walk_ctrl and the top level, not by the node RAM.
`default_nettype none

package bstse_pkg;

    localparam int NODE_CAP = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(NODE_CAP);
    localparam int LINK_W   = IDX_W + 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODE_CAP);
    localparam logic [LINK_W-1:0] FULL_COUNT = LINK_W'(NODE_CAP);

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_ADD    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] left;
        logic [LINK_W-1:0] right;
    } node_word_t;

    localparam int NODE_W = $bits(node_word_t);

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        node_word_t        wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_WR_NEW,
        ST_WR_PAR
    } walk_state_t;

    // a < b under the selected order; signed order flips the sign bits
    function automatic logic key_less(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic             signed_mode);
        logic [KEY_W-1:0] flip;
        flip = {signed_mode, {(KEY_W-1){1'b0}}};
        return (a ^ flip) < (b ^ flip);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bstse_node_ram.sv =====
// Generic single-port synchronous RAM, one write or one read per cycle.
// Read data registered. No package dependency.
`default_nettype none

module bstse_node_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bstse_walk_ctrl.sv =====
// Tree walk sequencer: root link, node count, compare and link update.
// Depends on bstse_pkg; drives the node RAM through a mem_req_t request.
`default_nettype none

module bstse_walk_ctrl
    import bstse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               kind,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic               signed_mode,
    output logic                    busy,
    output mem_req_t                mem_req,
    input  wire node_word_t         mem_rdata,
    output logic                    done,
    output logic                    found,
    output logic                    added,
    output logic                    full_res,
    output logic [IDX_W-1:0]        node_index
);

    walk_state_t       state_reg, state_next;
    logic              kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0]  parent_reg, parent_next;
    logic              has_parent_reg, has_parent_next;
    logic              side_left_reg, side_left_next;
    node_word_t        parent_word_reg, parent_word_next;
    logic [LINK_W-1:0] root_reg, root_next;
    logic [LINK_W-1:0] count_reg, count_next;

    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic              added_reg, added_next;
    logic              full_reg, full_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              key_eq;
    logic              key_lt;
    logic              walk_end;

    assign key_eq   = (key_reg == mem_rdata.key);
    assign key_lt   = key_less(key_reg, mem_rdata.key, signed_mode);
    // null marker and links past the fill both end the walk
    assign walk_end = (cur_reg >= count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!walk_end)
                begin
                    state_next = ST_CMP;
                end
                else if (kind_reg == KIND_ADD && count_reg != FULL_COUNT)
                begin
                    state_next = ST_WR_NEW;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                state_next = key_eq ? ST_IDLE : ST_FETCH;
            end
            ST_WR_NEW:
            begin
                state_next = has_parent_reg ? ST_WR_PAR : ST_IDLE;
            end
            ST_WR_PAR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next        = kind_reg;
        key_next         = key_reg;
        cur_next         = cur_reg;
        parent_next      = parent_reg;
        has_parent_next  = has_parent_reg;
        side_left_next   = side_left_reg;
        parent_word_next = parent_word_reg;
        root_next        = root_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        found_next       = found_reg;
        added_next       = added_reg;
        full_next        = full_reg;
        idx_next         = idx_reg;
        mem_req          = '0;
        mem_req.addr     = cur_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next       = kind;
                    key_next        = key;
                    cur_next        = root_reg;
                    has_parent_next = 1'b0;
                end
            end
            ST_FETCH:
            begin
                if (walk_end)
                begin
                    if (!(kind_reg == KIND_ADD && count_reg != FULL_COUNT))
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        added_next = 1'b0;
                        full_next  = (kind_reg == KIND_ADD);
                        idx_next   = '0;
                    end
                end
            end
            ST_CMP:
            begin
                if (key_eq)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    added_next = 1'b0;
                    full_next  = 1'b0;
                    idx_next   = cur_reg[IDX_W-1:0];
                end
                else
                begin
                    parent_next      = cur_reg[IDX_W-1:0];
                    has_parent_next  = 1'b1;
                    side_left_next   = key_lt;
                    parent_word_next = mem_rdata;
                    cur_next         = key_lt ? mem_rdata.left : mem_rdata.right;
                end
            end
            ST_WR_NEW:
            begin
                mem_req.we          = 1'b1;
                mem_req.addr        = count_reg[IDX_W-1:0];
                mem_req.wdata.key   = key_reg;
                mem_req.wdata.left  = NULL_LINK;
                mem_req.wdata.right = NULL_LINK;
                if (!has_parent_reg)
                begin
                    root_next  = count_reg;
                    count_next = count_reg + LINK_W'(1);
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    added_next = 1'b1;
                    full_next  = 1'b0;
                    idx_next   = count_reg[IDX_W-1:0];
                end
            end
            ST_WR_PAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = parent_reg;
                mem_req.wdata = parent_word_reg;
                if (side_left_reg)
                begin
                    mem_req.wdata.left = count_reg;
                end
                else
                begin
                    mem_req.wdata.right = count_reg;
                end
                count_next = count_reg + LINK_W'(1);
                done_next  = 1'b1;
                found_next = 1'b0;
                added_next = 1'b1;
                full_next  = 1'b0;
                idx_next   = count_reg[IDX_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= NULL_LINK;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            has_parent_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            has_parent_reg <= has_parent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        cur_reg         <= cur_next;
        parent_reg      <= parent_next;
        side_left_reg   <= side_left_next;
        parent_word_reg <= parent_word_next;
        found_reg       <= found_next;
        added_reg       <= added_next;
        full_reg        <= full_next;
        idx_reg         <= idx_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign added      = added_reg;
    assign full_res   = full_reg;
    assign node_index = idx_reg;

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("node count past capacity");

    a_add_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && added_reg) |-> (count_reg == $past(count_reg) + LINK_W'(1)))
        else $error("added transaction without count increment");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !((found_reg && added_reg) || (full_reg && (found_reg || added_reg))))
        else $error("conflicting result flags");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == ST_WR_NEW || state_reg == ST_WR_PAR))
        else $error("node write outside insert");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== rtl/array_bst_set_engine_core.sv =====
// Top level of the BST set engine: config register, walk sequencer, node RAM.
// Depends on bstse_pkg, bstse_walk_ctrl and bstse_node_ram.
`default_nettype none

// Keeps a set of up to 64 32-bit keys as an unbalanced binary search tree held
// in one 64-entry node RAM (key, left link, right link per node). A transaction
// is taken when start is high and busy is low; kind 0 searches, kind 1 adds.
// Each transaction gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall it. The accepting edge loads the root link;
// after it the walk visits each tree level with a RAM read, then a compare,
// as the single RAM port with its registered read sets the pace. A walk that
// runs off the tree ends with the fetch that meets the null link; an add of a
// new key then writes the node and relinks its parent (no relink for the first
// node). busy drops in the cycle that carries the result strobe.
// compare_signed (cfg_wr_en/cfg_wr_data) picks unsigned or two's complement
// key order. The user must write it only while the block is idle; the block
// itself does not enforce this.
// No clearing pass after reset: a node is only read after it has been written.
module array_bst_set_engine_core
    import bstse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              kind,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    output logic                   done,
    output logic                   found,
    output logic                   added,
    output logic                   full_res,
    output logic [IDX_W-1:0]       node_index
);

    logic       compare_signed_reg;
    mem_req_t   mem_req;
    logic [NODE_W-1:0] ram_rdata;
    node_word_t node_rdata;

    // order select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_signed_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            compare_signed_reg <= cfg_wr_data;
        end
    end

    assign node_rdata = node_word_t'(ram_rdata);

    bstse_walk_ctrl u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .key         (key),
        .signed_mode (compare_signed_reg),
        .busy        (busy),
        .mem_req     (mem_req),
        .mem_rdata   (node_rdata),
        .done        (done),
        .found       (found),
        .added       (added),
        .full_res    (full_res),
        .node_index  (node_index)
    );

    bstse_node_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_CAP)
    ) u_nodes (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for array_bst_set_engine_core: search/add transactions
// are checked against a tree predictor held in a small scoreboard class.
// Depends on rtl/bstse_pkg.sv and rtl/array_bst_set_engine_core.sv.
`timescale 1ns / 1ps

module tb_top;
    import bstse_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    // Settle time at the end, long enough for the worst walk on a degenerate tree.
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_ITEMS = 260;
    localparam int CHAIN_LEN = 20;
    localparam int ADD_PCT = 25;

    // One result as the block should report it.
    typedef struct {
        bit             found;
        bit             added;
        bit             full;
        bit [IDX_W-1:0] idx;
    } bst_outcome_t;

    // Keeps its own copy of the tree and the key order, predicts the outcome of
    // each accepted transaction and checks the strobed results in order.
    class bst_outcome_board;
        logic [KEY_W-1:0] keys[NODE_CAP];
        int unsigned      lefts[NODE_CAP];
        int unsigned      rights[NODE_CAP];
        int unsigned      root;
        int unsigned      count;
        bit               signed_mode;
        bst_outcome_t     pending_outcomes[$];
        int unsigned      errors;

        function new();
            root = NODE_CAP;
            count = 0;
            signed_mode = 1'b0;
            errors = 0;
        endfunction

        function bit precedes(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
            if (signed_mode)
                return $signed(a) < $signed(b);
            return a < b;
        endfunction

        // Walk the tree for an accepted transaction and queue what must come back.
        function void log_request(logic op, logic [KEY_W-1:0] k);
            int unsigned  cur;
            int unsigned  parent;
            int unsigned  steps;
            bit           went_left;
            bit           hit;
            bst_outcome_t o;
            cur = root;
            parent = NODE_CAP;
            steps = 0;
            went_left = 1'b0;
            hit = 1'b0;
            o = '{found: 1'b0, added: 1'b0, full: 1'b0, idx: '0};
            // links at or beyond the node count read as null
            while (!hit && cur < count && steps < NODE_CAP)
            begin
                if (keys[cur] == k)
                    hit = 1'b1;
                else
                begin
                    parent = cur;
                    went_left = precedes(k, keys[cur]);
                    cur = went_left ? lefts[cur] : rights[cur];
                    steps++;
                end
            end
            if (hit)
            begin
                o.found = 1'b1;
                o.idx = IDX_W'(cur);
            end
            else if (op == KIND_ADD)
            begin
                if (count >= NODE_CAP)
                    o.full = 1'b1;
                else
                begin
                    keys[count] = k;
                    lefts[count] = NODE_CAP;
                    rights[count] = NODE_CAP;
                    if (parent >= NODE_CAP)
                        root = count;
                    else if (went_left)
                        lefts[parent] = count;
                    else
                        rights[parent] = count;
                    o.added = 1'b1;
                    o.idx = IDX_W'(count);
                    count++;
                end
            end
            pending_outcomes.push_back(o);
        endfunction

        function void match_outcome(logic f, logic a, logic fl, logic [IDX_W-1:0] ix);
            bst_outcome_t o;
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (f !== o.found)
            begin
                $error("found: expected %0d, got %0d", o.found, f);
                errors++;
            end
            if (a !== o.added)
            begin
                $error("added: expected %0d, got %0d", o.added, a);
                errors++;
            end
            if (fl !== o.full)
            begin
                $error("full_res: expected %0d, got %0d", o.full, fl);
                errors++;
            end
            if (ix !== o.idx)
            begin
                $error("node_index: expected %0d, got %0d", o.idx, ix);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             kind = KIND_SEARCH;
    logic [KEY_W-1:0] key = '0;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_wr_data = 1'b0;
    logic             busy;
    logic             done;
    logic             found;
    logic             added;
    logic             full_res;
    logic [IDX_W-1:0] node_index;

    bst_outcome_board board;
    int unsigned      cycle_count = 0;

    array_bst_set_engine_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .key        (key),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .found      (found),
        .added      (added),
        .full_res   (full_res),
        .node_index (node_index)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Results cannot be held off: sample every strobe at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.match_outcome(found, added, full_res, node_index);
    end

    // Watchdog against a hung walk or a lost result.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // All tasks below are entered and left on a rising-edge time step.

    // Offer one transaction, idling first at the given rate; returns on the edge
    // that accepts it. start stays high so back-to-back transactions need no gap.
    task automatic send_op(logic op, logic [KEY_W-1:0] k, int unsigned idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        kind <= op;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.log_request(op, k);
    endtask

    // Sender holds off until every outstanding result has been seen; with none
    // outstanding start is already low and nothing is driven.
    task automatic drain_results();
        if (board.pending_outcomes.size() != 0)
        begin
            start <= 1'b0;
            while (board.pending_outcomes.size() != 0)
                @(posedge clk);
        end
    endtask

    // Only called with the block idle.
    task automatic set_key_order(bit is_signed);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= is_signed;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.signed_mode = is_signed;
    endtask

    // Mix of hits on stored keys, order extremes and fresh random keys.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40 && board.count > 0)
            return board.keys[$urandom_range(board.count - 1)];
        if (roll < 50)
        begin
            case ($urandom_range(4))
                0: return '0;
                1: return '1;
                2: return {1'b1, {(KEY_W-1){1'b0}}};
                3: return {1'b0, {(KEY_W-1){1'b1}}};
                default: return KEY_W'(1);
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_phase(int unsigned idle_pct, bit with_chain);
        logic [KEY_W-1:0] chain_key;
        logic             op;
        if (with_chain)
        begin
            // ascending run builds a one-sided, deep branch
            chain_key = 32'hA000_0000 + $urandom_range(0, 'hFFFF);
            repeat (CHAIN_LEN)
            begin
                send_op(KIND_ADD, chain_key, idle_pct);
                chain_key += $urandom_range(1, 'h0400_0000);
            end
        end
        repeat (PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 2)
                drain_results();
            op = ($urandom_range(99) < ADD_PCT) ? KIND_ADD : KIND_SEARCH;
            send_op(op, pick_key(), idle_pct);
        end
        drain_results();
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_key_order(1'b0);

        // Directed: empty-tree misses, root, duplicate add, order extremes.
        send_op(KIND_SEARCH, '0, 0);
        send_op(KIND_SEARCH, '1, 0);
        send_op(KIND_ADD, 32'h8000_0000, 0);
        send_op(KIND_ADD, 32'h8000_0000, 0);
        send_op(KIND_ADD, 32'h0000_0000, 0);
        send_op(KIND_ADD, 32'hFFFF_FFFF, 0);
        send_op(KIND_ADD, 32'h7FFF_FFFF, 0);
        send_op(KIND_ADD, 32'h0000_0001, 0);
        send_op(KIND_ADD, 32'hFFFF_FFFE, 0);
        send_op(KIND_SEARCH, 32'h0000_0000, 0);
        send_op(KIND_SEARCH, 32'hFFFF_FFFF, 0);
        send_op(KIND_SEARCH, 32'h7FFF_FFFF, 0);
        send_op(KIND_SEARCH, 32'h1234_5678, 0);
        send_op(KIND_ADD, 32'h1234_5678, 0);
        send_op(KIND_SEARCH, 32'h1234_5678, 0);
        send_op(KIND_ADD, 32'hFFFF_FFFF, 0);
        drain_results();

        // Signed order over a tree partly built unsigned; the store can fill in these
        // phases, and adds of new keys are then refused.
        set_key_order(1'b1);
        random_phase(27, 1'b1);
        set_key_order(1'b0);
        random_phase(47, 1'b0);
        set_key_order(1'b1);
        random_phase(0, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
